@@ design/twv_pkg.sv @@
package twv_pkg;

	// Width of one control value, signed Q1.15 at the default width.
	localparam int VALUE_WIDTH = 16;
	// The tolerance register is always 15 bits wide.
	localparam int TOL_W       = 15;
	localparam int NUM_CH      = 3;

	// Channel positions in the channel arrays.
	localparam int CH_A   = 0;
	localparam int CH_B   = 1;
	localparam int CH_OWN = 2;

	// Sum of three values, its magnitude and the reciprocal used to divide by three.
	localparam int SUM_W   = VALUE_WIDTH + 2;
	localparam int MAG_W   = VALUE_WIDTH + 1;
	localparam int RECIP_K = MAG_W;
	localparam int PROD_W  = MAG_W + RECIP_K;
	localparam logic [RECIP_K-1:0] RECIP3 = RECIP_K'((64'd1 << RECIP_K) / 3);

	// Deviation magnitudes and the width used to compare them with the tolerance.
	localparam int DEV_W = VALUE_WIDTH + 1;
	localparam int CMP_W = (DEV_W > TOL_W) ? DEV_W : TOL_W;

	typedef logic signed [VALUE_WIDTH-1:0] value_t;
	typedef logic signed [SUM_W-1:0]       sum_t;
	typedef logic [TOL_W-1:0]              tol_t;
	typedef logic [DEV_W-1:0]              dev_t;

	// 0.02 in Q1.15, truncated.
	localparam tol_t TOL_RESET = TOL_W'(655);

	typedef enum logic [1:0] {
		DEC_ALL  = 2'd0,
		DEC_PAIR = 2'd1,
		DEC_OWN  = 2'd2
	} decision_t;

	typedef enum logic [1:0] {
		EXCL_A    = 2'd0,
		EXCL_B    = 2'd1,
		EXCL_OWN  = 2'd2,
		EXCL_NONE = 2'd3
	} excl_t;

	// Magnitude of the difference of two values.
	function automatic dev_t abs_diff(value_t x, value_t y);
		logic signed [DEV_W-1:0] d;
		d = DEV_W'(x) - DEV_W'(y);
		return d[DEV_W-1] ? dev_t'(-d) : dev_t'(d);
	endfunction

	// True when a deviation magnitude counts as agreement.
	function automatic logic within_tol(dev_t d, tol_t t);
		return CMP_W'(d) <= CMP_W'(t);
	endfunction

endpackage

@@ design/twv_div3.sv @@
module twv_div3 import twv_pkg::*; (
	input  logic   clk,
	input  sum_t   sum_s1,
	output value_t mean_s3
);

	// Division by three, truncated toward zero, done on the magnitude: a multiply by the
	// reciprocal in the first stage, then one correction step and the sign in the second.
	logic [SUM_W-1:0]   abs_full;
	logic [MAG_W-1:0]   mag;
	logic [PROD_W-1:0]  prod;
	logic [MAG_W-1:0]   q0_s2;
	logic [MAG_W-1:0]   mag_s2;
	logic               neg_s2;
	logic [MAG_W:0]     three_q;
	logic [MAG_W:0]     rem;
	logic [MAG_W-1:0]   quot;

	always_comb begin
		abs_full = sum_s1[SUM_W-1] ? SUM_W'(-sum_s1) : SUM_W'(sum_s1);
		mag      = abs_full[MAG_W-1:0];
		prod     = PROD_W'(mag) * PROD_W'(RECIP3);
	end

	always_ff @(posedge clk) begin
		q0_s2  <= prod[PROD_W-1:RECIP_K];
		mag_s2 <= mag;
		neg_s2 <= sum_s1[SUM_W-1];
	end

	// The estimate is at most one below the true quotient.
	always_comb begin
		three_q = {q0_s2, 1'b0} + {1'b0, q0_s2};
		rem     = {1'b0, mag_s2} - three_q;
		quot    = q0_s2 + MAG_W'(rem >= (MAG_W + 1)'(3));
	end

	always_ff @(posedge clk) begin
		mean_s3 <= neg_s2 ? value_t'(-quot) : value_t'(quot);
	end

endmodule

@@ design/twv_lane.sv @@
module twv_lane import twv_pkg::*; (
	input  logic   clk,
	input  value_t value_s3,
	input  value_t mean_s3,
	input  tol_t   tolerance,
	output dev_t   dev_s4
);

	// Deviation of one channel from the mean of three; inside tolerance it counts as zero.
	dev_t dev;

	always_comb begin
		dev = abs_diff(value_s3, mean_s3);
	end

	always_ff @(posedge clk) begin
		dev_s4 <= within_tol(dev, tolerance) ? '0 : dev;
	end

endmodule

@@ design/twv_merge.sv @@
module twv_merge import twv_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         valid_s4,
	input  dev_t         dev_s4 [NUM_CH],
	input  value_t       ch_s4 [NUM_CH],
	input  value_t       mean_s4,
	input  tol_t         tolerance,
	output logic         done,
	output value_t       voted_value,
	output logic [1:0]   decision,
	output logic [1:0]   excluded_channel
);

	typedef struct packed {
		logic  any;
		excl_t worst;
	} vote_ctl_t;

	vote_ctl_t ctl;
	value_t    va;
	value_t    vb;

	logic      v_s5, v_s6, v_s7;
	vote_ctl_t ctl_s5, ctl_s6;
	value_t    va_s5, vb_s5, own_s5, mean_s5;
	value_t    va_s6, vb_s6, own_s6, mean_s6, pmean_s6;
	logic signed [VALUE_WIDTH:0] psum;
	logic signed [VALUE_WIDTH:0] pround;
	logic      pair_ok;
	value_t    voted_s7;
	decision_t decision_s7;
	excl_t     excluded_s7;

	// Largest deviation wins; a tie keeps the lower channel.
	always_comb begin
		ctl.any = (dev_s4[CH_A] != '0) || (dev_s4[CH_B] != '0) || (dev_s4[CH_OWN] != '0);
		if (dev_s4[CH_A] < dev_s4[CH_B]) begin
			ctl.worst = (dev_s4[CH_B] < dev_s4[CH_OWN]) ? EXCL_OWN : EXCL_B;
		end else begin
			ctl.worst = (dev_s4[CH_A] < dev_s4[CH_OWN]) ? EXCL_OWN : EXCL_A;
		end
		unique case (ctl.worst)
			EXCL_A: begin
				va = ch_s4[CH_B];
				vb = ch_s4[CH_OWN];
			end
			EXCL_B: begin
				va = ch_s4[CH_A];
				vb = ch_s4[CH_OWN];
			end
			default: begin
				va = ch_s4[CH_A];
				vb = ch_s4[CH_B];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		ctl_s5  <= ctl;
		va_s5   <= va;
		vb_s5   <= vb;
		own_s5  <= ch_s4[CH_OWN];
		mean_s5 <= mean_s4;
	end

	// Mean of the remaining pair, truncated toward zero.
	always_comb begin
		psum   = (VALUE_WIDTH + 1)'(va_s5) + (VALUE_WIDTH + 1)'(vb_s5);
		pround = psum + $signed({{VALUE_WIDTH{1'b0}}, psum[VALUE_WIDTH]});
	end

	always_ff @(posedge clk) begin
		ctl_s6   <= ctl_s5;
		va_s6    <= va_s5;
		vb_s6    <= vb_s5;
		own_s6   <= own_s5;
		mean_s6  <= mean_s5;
		pmean_s6 <= pround[VALUE_WIDTH:1];
	end

	always_comb begin
		pair_ok = within_tol(abs_diff(va_s6, pmean_s6), tolerance)
			&& within_tol(abs_diff(vb_s6, pmean_s6), tolerance);
	end

	always_ff @(posedge clk) begin
		if (!ctl_s6.any) begin
			voted_s7    <= mean_s6;
			decision_s7 <= DEC_ALL;
			excluded_s7 <= EXCL_NONE;
		end else if (pair_ok) begin
			voted_s7    <= pmean_s6;
			decision_s7 <= DEC_PAIR;
			excluded_s7 <= ctl_s6.worst;
		end else begin
			voted_s7    <= own_s6;
			decision_s7 <= DEC_OWN;
			excluded_s7 <= ctl_s6.worst;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s5 <= valid_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	assign done             = v_s7;
	assign voted_value      = voted_s7;
	assign decision         = decision_s7;
	assign excluded_channel = excluded_s7;

	a_all_means_none: assert property (@(posedge clk) disable iff (!arst_n)
		(done && decision == DEC_ALL) |-> excluded_channel == EXCL_NONE)
		else $error("full agreement reported with an excluded channel");

	a_split_names_channel: assert property (@(posedge clk) disable iff (!arst_n)
		(done && decision != DEC_ALL) |-> excluded_channel != EXCL_NONE)
		else $error("disagreement reported without an excluded channel");

	a_decision_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (decision == DEC_ALL || decision == DEC_PAIR || decision == DEC_OWN))
		else $error("unknown decision code delivered");

endmodule

@@ design/three_way_tolerance_voter.sv @@
// Channel     | Direction | Handshake          | Payload
// ------------+-----------+--------------------+---------------------------------------------
// input item  | in        | start, busy        | own_value, peer_a/b_value, peer_a/b_valid
// result      | out       | done (strobe)      | voted_value, decision, excluded_channel
// tolerance   | in        | tolerance_we       | tolerance_wdata
//
// A new item may be started in every cycle; busy is always low.
// Each item gives one result, registered through the pipeline stages of input
// register, reciprocal multiply, quotient correction, lane deviations, worst-channel choice,
// pair mean and final selection.
// Reset clears the pipeline valid bits and loads the tolerance with 0.02 in Q1.15.
// The receiver cannot stall: done is high for one cycle per result.
module three_way_tolerance_voter import twv_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  value_t       own_value,
	input  value_t       peer_a_value,
	input  logic         peer_a_valid,
	input  value_t       peer_b_value,
	input  logic         peer_b_valid,
	input  logic         tolerance_we,
	input  tol_t         tolerance_wdata,
	output logic         done,
	output value_t       voted_value,
	output logic [1:0]   decision,
	output logic [1:0]   excluded_channel
);

	logic   accept;
	tol_t   tol_q;
	value_t a_sel;
	value_t b_sel;
	sum_t   sum_in;

	logic   v_s1, v_s2, v_s3, v_s4;
	value_t ch_s1 [NUM_CH];
	value_t ch_s2 [NUM_CH];
	value_t ch_s3 [NUM_CH];
	value_t ch_s4 [NUM_CH];
	sum_t   sum_s1;
	value_t mean_s3;
	value_t mean_s4;
	dev_t   dev_s4 [NUM_CH];

	// There is no back-pressure anywhere in the pipeline.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// The tolerance is to be rewritten only while no transfer is in flight, so that every stage
	// reads the live register; the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (tolerance_we) begin
			tol_q <= tolerance_wdata;
		end
	end

	// An invalid peer value is replaced by the own value before anything else.
	always_comb begin
		a_sel  = peer_a_valid ? peer_a_value : own_value;
		b_sel  = peer_b_valid ? peer_b_value : own_value;
		sum_in = sum_t'(a_sel) + sum_t'(b_sel) + sum_t'(own_value);
	end

	// The channel values travel alongside the divider until the lanes need them.
	always_ff @(posedge clk) begin
		ch_s1[CH_A]   <= a_sel;
		ch_s1[CH_B]   <= b_sel;
		ch_s1[CH_OWN] <= own_value;
		sum_s1        <= sum_in;
		ch_s2         <= ch_s1;
		ch_s3         <= ch_s2;
		ch_s4         <= ch_s3;
		mean_s4       <= mean_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Mean of the three channels, truncated toward zero.
	twv_div3 u_div3 (
		.clk     (clk),
		.sum_s1  (sum_s1),
		.mean_s3 (mean_s3)
	);

	// One lane per channel measures its deviation from the mean.
	for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
		twv_lane u_lane (
			.clk       (clk),
			.value_s3  (ch_s3[g]),
			.mean_s3   (mean_s3),
			.tolerance (tol_q),
			.dev_s4    (dev_s4[g])
		);
	end

	// The merging stage picks the channel to drop, forms the pair mean and decides.
	twv_merge u_merge (
		.clk              (clk),
		.arst_n           (arst_n),
		.valid_s4         (v_s4),
		.dev_s4           (dev_s4),
		.ch_s4            (ch_s4),
		.mean_s4          (mean_s4),
		.tolerance        (tol_q),
		.done             (done),
		.voted_value      (voted_value),
		.decision         (decision),
		.excluded_channel (excluded_channel)
	);

endmodule
